[hdl/nalsplit_pkg.sv]
package nalsplit_pkg;

   // Default widths of the internal counters
   localparam int LENGTH_BITS_DEF = 24;
   localparam int OFFSET_BITS_DEF = 32;

   // Fixed field widths of the result transaction
   localparam int IDX_W     = 24;
   localparam int OUT_LEN_W = 24;
   localparam int OUT_OFF_W = 32;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NAL_LIMIT    = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  NAL_LIMIT_RESET  = 16'd300;

   // Record status codes
   localparam logic STATUS_UNIT     = 1'b0;
   localparam logic STATUS_NO_START = 1'b1;

   // Start code lengths
   localparam logic [2:0] PREFIX_SHORT = 3'd3;
   localparam logic [2:0] PREFIX_LONG  = 3'd4;

   // Result queue depth (two pushes per cycle at most)
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic                  limit_enable;
      logic [CSR_DATA_W-1:0] nal_limit;
   } cfg_type;

   typedef struct packed {
      logic                 status;
      logic [IDX_W-1:0]     unit_index;
      logic [OUT_OFF_W-1:0] byte_offset;
      logic [OUT_LEN_W-1:0] payload_length;
      logic [2:0]           prefix_length;
      logic                 forbid_flag;
      logic [1:0]           ref_idc;
      logic [4:0]           unit_type;
      logic                 limit_reached;
      logic                 last_of_run;
   } nal_rec_type;

   // Records produced by one byte: rec_a goes first, rec_b second
   typedef struct packed {
      logic [1:0]  count;
      nal_rec_type rec_a;
      nal_rec_type rec_b;
   } rsp_pair_type;

endpackage

[hdl/nalsplit_req_if.sv]
interface nalsplit_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       end_of_stream;

   modport source (output valid, output stream_byte, output end_of_stream, input ready);
   modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

[hdl/nalsplit_rsp_if.sv]
interface nalsplit_rsp_if;
   import nalsplit_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 status;
   logic [IDX_W-1:0]     unit_index;
   logic [OUT_OFF_W-1:0] byte_offset;
   logic [OUT_LEN_W-1:0] payload_length;
   logic [2:0]           prefix_length;
   logic                 forbid_flag;
   logic [1:0]           ref_idc;
   logic [4:0]           unit_type;
   logic                 limit_reached;
   logic                 last_of_run;

   modport source (
      output valid, output status, output unit_index, output byte_offset,
      output payload_length, output prefix_length, output forbid_flag,
      output ref_idc, output unit_type, output limit_reached, output last_of_run,
      input ready
   );
   modport sink (
      input valid, input status, input unit_index, input byte_offset,
      input payload_length, input prefix_length, input forbid_flag,
      input ref_idc, input unit_type, input limit_reached, input last_of_run,
      output ready
   );
endinterface

[hdl/nalsplit_csr_if.sv]
interface nalsplit_csr_if;
   import nalsplit_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/nalsplit_step.sv]
module nalsplit_step #(
   parameter int LENGTH_BITS = nalsplit_pkg::LENGTH_BITS_DEF,
   parameter int OFFSET_BITS = nalsplit_pkg::OFFSET_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [7:0]                 stream_byte,
   input  logic                       end_of_stream,
   input  nalsplit_pkg::cfg_type      cfg,
   output nalsplit_pkg::rsp_pair_type pair
);
   import nalsplit_pkg::*;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   // stream state
   logic [23:0]            recent_ff,  recent_in;
   logic [1:0]             lead_ff,    lead_in;
   logic                   in_unit_ff, in_unit_in;
   logic                   resync_ff,  resync_in;
   logic                   long_ff,    long_in;
   logic [LENGTH_BITS-1:0] count_ff,   count_in;
   logic [OFFSET_BITS-1:0] start_ff,   start_in;
   logic [OFFSET_BITS-1:0] pos_ff,     pos_in;
   logic [7:0]             header_ff,  header_in;
   logic [IDX_W-1:0]       counter_ff, counter_in;
   logic                   halted_ff,  halted_in;

   // per-byte decode
   logic z1, z2, z3, b_one, b_zero, seek, sc, sc_long;
   logic open_unit, open_long, err_open, grow;
   logic v1, v2, halted_mid, in_unit_mid, resync_mid, long_mid;
   logic [LENGTH_BITS-1:0] count_mid;
   logic [7:0]             header_mid;
   logic [OFFSET_BITS-1:0] start_mid;
   logic [IDX_W-1:0]       counter_mid;
   nal_rec_type r1, r2, err_rec;

   function automatic nal_rec_type unit_rec(
      input logic [LENGTH_BITS-1:0] cnt,
      input logic [1:0]             sub,
      input logic [7:0]             hdr,
      input logic [IDX_W-1:0]       idx,
      input logic [OFFSET_BITS-1:0] start,
      input logic                   long_prefix,
      input cfg_type                c
   );
      nal_rec_type            r;
      logic [LENGTH_BITS-1:0] len;
      logic [7:0]             hb;
      logic [IDX_W:0]         next_idx;
      if (cnt == LEN_MAX) begin
         len = LEN_MAX;
      end else if (cnt < LENGTH_BITS'(sub)) begin
         len = '0;
      end else begin
         len = cnt - LENGTH_BITS'(sub);
      end
      // empty unit: no header byte to report
      hb = (len == '0) ? 8'h00 : hdr;
      next_idx = {1'b0, idx} + 1'b1;
      r = '0;
      r.status         = STATUS_UNIT;
      r.unit_index     = idx;
      r.byte_offset    = OUT_OFF_W'(start);
      r.payload_length = OUT_LEN_W'(len);
      r.prefix_length  = long_prefix ? PREFIX_LONG : PREFIX_SHORT;
      r.forbid_flag    = hb[7];
      r.ref_idc        = hb[6:5];
      r.unit_type      = hb[4:0];
      r.limit_reached  = c.limit_enable && (next_idx >= (IDX_W+1)'(c.nal_limit));
      return r;
   endfunction

   always_comb begin
      z1     = recent_ff[7:0] == 8'h00;
      z2     = recent_ff[15:8] == 8'h00;
      z3     = recent_ff[23:16] == 8'h00;
      b_one  = stream_byte == 8'h01;
      b_zero = stream_byte == 8'h00;
      seek   = !in_unit_ff && !resync_ff;

      // start code after the stream opening
      sc      = !seek && b_one && lead_ff[1] && z1 && z2;
      sc_long = (lead_ff == 2'd3) && z3;

      // opening of the stream: position 2 or 3 decides
      open_unit = sc
               || (seek && (pos_ff == OFFSET_BITS'(2)) && z2 && z1 && b_one)
               || (seek && (pos_ff == OFFSET_BITS'(3)) && b_one);
      open_long = seek ? (pos_ff == OFFSET_BITS'(3)) : sc_long;
      err_open  = seek && (((pos_ff == OFFSET_BITS'(2)) && !(z2 && z1 && (b_one || b_zero)))
                        || ((pos_ff == OFFSET_BITS'(3)) && !b_one));
      grow      = !seek && !sc && in_unit_ff;

      err_rec        = '0;
      err_rec.status = STATUS_NO_START;

      // first record: the unit closed by a start code, or the opening error
      r1 = err_open ? err_rec
                    : unit_rec(count_ff, sc_long ? 2'd3 : 2'd2, header_ff, counter_ff,
                               start_ff, long_ff, cfg);
      v1 = fire && !halted_ff && ((sc && in_unit_ff) || err_open);

      halted_mid  = halted_ff || (v1 && r1.limit_reached);
      counter_mid = counter_ff + IDX_W'(v1 && !err_open);
      in_unit_mid = in_unit_ff || open_unit;
      resync_mid  = err_open || (resync_ff && !sc);
      long_mid    = open_unit ? open_long : long_ff;
      start_mid   = open_unit ? pos_ff - (open_long ? OFFSET_BITS'(3) : OFFSET_BITS'(2))
                              : start_ff;
      if (open_unit) begin
         count_mid  = '0;
         header_mid = 8'h00;
      end else if (grow) begin
         count_mid  = (count_ff == LEN_MAX) ? count_ff : count_ff + 1'b1;
         header_mid = (count_ff == '0) ? stream_byte : header_ff;
      end else begin
         count_mid  = count_ff;
         header_mid = header_ff;
      end

      // second record: end of stream flushes the open unit
      r2 = in_unit_mid ? unit_rec(count_mid, 2'd0, header_mid, counter_mid, start_mid,
                                  long_mid, cfg)
                       : err_rec;
      v2 = fire && end_of_stream && !halted_mid && (in_unit_mid || !resync_mid);
      r2.last_of_run = 1'b1;
      r1.last_of_run = !v2;

      pair.count = {v1 && v2, v1 ^ v2};
      pair.rec_a = v1 ? r1 : r2;
      pair.rec_b = r2;

      if (end_of_stream) begin
         recent_in  = '0;
         lead_in    = '0;
         in_unit_in = 1'b0;
         resync_in  = 1'b0;
         long_in    = 1'b0;
         count_in   = '0;
         start_in   = '0;
         pos_in     = '0;
         header_in  = 8'h00;
         counter_in = '0;
         halted_in  = 1'b0;
      end else begin
         recent_in  = {recent_ff[15:0], stream_byte};
         lead_in    = (lead_ff == 2'd3) ? lead_ff : lead_ff + 1'b1;
         in_unit_in = in_unit_mid;
         resync_in  = resync_mid;
         long_in    = long_mid;
         count_in   = count_mid;
         start_in   = start_mid;
         pos_in     = pos_ff + 1'b1;
         header_in  = header_mid;
         counter_in = counter_mid;
         halted_in  = halted_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff  <= '0;
         lead_ff    <= '0;
         in_unit_ff <= 1'b0;
         resync_ff  <= 1'b0;
         long_ff    <= 1'b0;
         count_ff   <= '0;
         start_ff   <= '0;
         pos_ff     <= '0;
         header_ff  <= 8'h00;
         counter_ff <= '0;
         halted_ff  <= 1'b0;
      end else if (fire) begin
         recent_ff  <= recent_in;
         lead_ff    <= lead_in;
         in_unit_ff <= in_unit_in;
         resync_ff  <= resync_in;
         long_ff    <= long_in;
         count_ff   <= count_in;
         start_ff   <= start_in;
         pos_ff     <= pos_in;
         header_ff  <= header_in;
         counter_ff <= counter_in;
         halted_ff  <= halted_in;
      end
   end

   // two records only when a start code ends the stream
   a_two_needs_eos: assert property (@(posedge clock) disable iff (reset)
      (pair.count == 2'd2) |-> (fire && end_of_stream))
      else $error("two records without end of stream");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && !(fire && end_of_stream)) |=> halted_ff)
      else $error("halt dropped inside a stream");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && end_of_stream) |=> (pos_ff == '0 && !in_unit_ff && !resync_ff))
      else $error("stream state not cleared after end of stream");

endmodule

[hdl/nalsplit_fifo.sv]
module nalsplit_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  nalsplit_pkg::rsp_pair_type pair,
   output logic                       space_ok,
   output logic                       out_valid,
   output nalsplit_pkg::nal_rec_type  out_rec,
   input  logic                       out_ready
);
   import nalsplit_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   nal_rec_type        mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff,    cnt_in;
   logic [PTR_W-1:0]   wr_next;
   logic               pop;

   always_comb begin
      pop       = out_valid && out_ready;
      wr_next   = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + PTR_W'(pair.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      cnt_in    = cnt_ff + CNT_W'(pair.count) - CNT_W'(pop);
   end

   assign out_valid = cnt_ff != '0;
   assign out_rec   = mem_ff[rd_ptr_ff];
   // room for a full pair without counting this cycle's pop
   assign space_ok  = cnt_ff <= CNT_W'(RSP_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= pair.rec_a;
      end
      if (pair.count == 2'd2) begin
         mem_ff[wr_next] <= pair.rec_b;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (pair.count != 2'd0) |-> (cnt_ff <= CNT_W'(RSP_DEPTH - 2)))
      else $error("push into a queue without room");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RSP_DEPTH))
      else $error("queue count out of range");

endmodule

[hdl/annexb_nal_unit_splitter_core.sv]
// Annex B NAL unit splitter. Scans an H.264 Annex B byte stream one byte per req_
// transaction and reports each NAL unit as a rsp_ transaction: running index, stream
// offset of its start code, payload length without the start code (saturating), prefix
// length (3 or 4), and the forbidden bit, reference idc and unit type of its first
// payload byte. A unit is reported when the next start code completes or when the byte
// flagged end_of_stream arrives, so a byte causes zero, one or two records; last_of_run
// marks the final one. A stream that does not open with a start code yields one error
// record (status 1) and the block then waits for the next start code. With limit_enable
// set, reporting stops after nal_limit unit records (at least one) until end of stream.
// Throughput is one byte per clock: the byte goes to an input register, the whole
// per-byte update of the stream state is one combinational pass, and records land in a
// four-entry queue. The input stalls only when that queue holds more than two records,
// i.e. when rsp_ is backpressured. Write the csr_ registers only while the block is idle.
module annexb_nal_unit_splitter_core #(
   parameter int LENGTH_BITS = nalsplit_pkg::LENGTH_BITS_DEF,
   parameter int OFFSET_BITS = nalsplit_pkg::OFFSET_BITS_DEF
) (
   input logic             clock,
   input logic             reset,
   nalsplit_req_if.sink    req_chan,
   nalsplit_rsp_if.source  rsp_chan,
   nalsplit_csr_if.sink    csr_chan
);
   import nalsplit_pkg::*;

   // configuration registers
   logic                  limit_enable_ff, limit_enable_in;
   logic [CSR_DATA_W-1:0] nal_limit_ff,    nal_limit_in;
   cfg_type               cfg;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_eos_ff;

   logic         req_accept;
   logic         fire;
   logic         space_ok;
   rsp_pair_type pair;
   nal_rec_type  out_rec;

   // --- configuration port: always ready, decoded by index ---
   assign csr_chan.ready = 1'b1;

   always_comb begin
      limit_enable_in = limit_enable_ff;
      nal_limit_in    = nal_limit_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_LIMIT_ENABLE: limit_enable_in = csr_chan.data[0];
            REG_NAL_LIMIT:    nal_limit_in    = csr_chan.data;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         nal_limit_ff    <= NAL_LIMIT_RESET;
      end else begin
         limit_enable_ff <= limit_enable_in;
         nal_limit_ff    <= nal_limit_in;
      end
   end

   assign cfg.limit_enable = limit_enable_ff;
   assign cfg.nal_limit    = nal_limit_ff;

   // --- input register ---
   // The held byte is processed once the queue has room for a full pair of records;
   // the register refills in the same cycle, so the stream moves at one byte per clock.
   assign fire           = s1_valid_ff && space_ok;
   assign req_chan.ready = !s1_valid_ff || space_ok;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_chan.stream_byte;
         s1_eos_ff  <= req_chan.end_of_stream;
      end
   end

   // --- start code detection and unit bookkeeping ---
   nalsplit_step #(
      .LENGTH_BITS (LENGTH_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .stream_byte   (s1_byte_ff),
      .end_of_stream (s1_eos_ff),
      .cfg           (cfg),
      .pair          (pair)
   );

   // --- result queue ---
   nalsplit_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .space_ok  (space_ok),
      .out_valid (rsp_chan.valid),
      .out_rec   (out_rec),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.status         = out_rec.status;
   assign rsp_chan.unit_index     = out_rec.unit_index;
   assign rsp_chan.byte_offset    = out_rec.byte_offset;
   assign rsp_chan.payload_length = out_rec.payload_length;
   assign rsp_chan.prefix_length  = out_rec.prefix_length;
   assign rsp_chan.forbid_flag    = out_rec.forbid_flag;
   assign rsp_chan.ref_idc        = out_rec.ref_idc;
   assign rsp_chan.unit_type      = out_rec.unit_type;
   assign rsp_chan.limit_reached  = out_rec.limit_reached;
   assign rsp_chan.last_of_run    = out_rec.last_of_run;

   // a held byte is never overwritten before it is processed
   a_hold_until_fire: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !fire) |-> !req_accept)
      else $error("input register overwritten");

endmodule

[test/annexb_nal_unit_splitter_core_test.sv]
`timescale 1ns / 1ps

module annexb_nal_unit_splitter_core_test;
   import nalsplit_pkg::*;

   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 8;     // well past the accept-to-record latency
   localparam int          HOLD_CYCLES   = 150;   // long rsp_ stall to back up the block
   localparam logic [23:0] COUNT_MAX     = 24'hFFFFFF;

   // one byte of the Annex B stream as it waits for the req_ channel
   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } scan_item_type;

   logic clock;
   logic reset;

   nalsplit_req_if req_bus ();
   nalsplit_rsp_if rsp_bus ();
   nalsplit_csr_if csr_bus ();

   annexb_nal_unit_splitter_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   // Stimulus and expected records
   scan_item_type stream_bytes[$];
   nal_rec_type   predicted_records[$];

   int fault_count = 0;
   int cycle_count = 0;

   // Traffic shaping, set by the sequencer, read by driver and monitor
   int tx_idle_pct;
   int rx_idle_pct;
   bit pressure_req;

   // Owned by the monitor
   int hold_left     = 0;
   bit pressure_done = 0;

   // ---------------------------------------------------------------------------------
   // Splitter state as the predictor sees it
   // ---------------------------------------------------------------------------------
   bit          limit_on;
   logic [15:0] limit_count;

   logic [23:0] history;            // last three bytes, newest in [7:0]
   int          history_len;        // valid bytes in history, stops at 3
   bit          unit_open;
   logic [2:0]  unit_prefix_len;
   logic [23:0] unit_bytes;         // bytes after the prefix, saturating
   logic [31:0] unit_offset;
   logic [31:0] position;
   logic [7:0]  unit_header;
   logic [23:0] unit_number;
   bit          reporting_stopped;  // nal_limit hit, quiet until end of stream
   bit          hunting;            // after a bad opening, until the next start code

   task automatic restart_stream();
      history           = '0;
      history_len       = 0;
      unit_open         = 0;
      unit_prefix_len   = PREFIX_SHORT;
      unit_bytes        = '0;
      unit_offset       = '0;
      position          = '0;
      unit_header       = '0;
      unit_number       = '0;
      reporting_stopped = 0;
      hunting           = 0;
   endtask

   task automatic open_nal(input logic [2:0] prefix, input logic [31:0] pos);
      unit_open       = 1;
      unit_prefix_len = prefix;
      unit_bytes      = '0;
      unit_header     = '0;
      // offset points at the first byte of the start code
      unit_offset     = pos - {29'd0, prefix} + 32'd1;
   endtask

   task automatic report_no_start();
      nal_rec_type rec;
      if (reporting_stopped) return;
      rec        = '0;
      rec.status = STATUS_NO_START;
      predicted_records.insert(predicted_records.size(), rec);
   endtask

   // sub = zero bytes of the next start code that were counted as payload
   task automatic report_unit(input logic [2:0] sub);
      nal_rec_type rec;
      logic [23:0] len;
      logic [7:0]  hdr;
      if (reporting_stopped) return;
      if (unit_bytes == COUNT_MAX)
         len = COUNT_MAX;
      else if (unit_bytes < {21'd0, sub})
         len = '0;
      else
         len = unit_bytes - {21'd0, sub};
      // empty unit: header fields read as zero
      hdr = (len == '0) ? 8'h00 : unit_header;
      rec                = '0;
      rec.status         = STATUS_UNIT;
      rec.unit_index     = unit_number;
      rec.byte_offset    = unit_offset;
      rec.payload_length = len;
      rec.prefix_length  = unit_prefix_len;
      rec.forbid_flag    = hdr[7];
      rec.ref_idc        = hdr[6:5];
      rec.unit_type      = hdr[4:0];
      if (limit_on && ({8'd0, unit_number} + 32'd1 >= {16'd0, limit_count})) begin
         rec.limit_reached = 1'b1;
         reporting_stopped = 1;
      end
      unit_number = unit_number + 24'd1;
      predicted_records.insert(predicted_records.size(), rec);
   endtask

   // Advance the predicted stream state by one accepted byte
   task automatic scan_byte(input logic [7:0] b, input logic eos);
      logic [31:0] pos;
      logic        z1, z2, z3;
      logic [2:0]  p;
      int          first;
      nal_rec_type tail;
      first = predicted_records.size();
      pos   = position;
      z1    = (history[7:0] == 8'h00);
      z2    = (history[15:8] == 8'h00);
      z3    = (history[23:16] == 8'h00);

      if (!unit_open && !hunting) begin
         // stream opening: decided at byte 2, or at byte 3 after 00 00 00
         if (pos == 32'd2) begin
            if (z2 && z1 && b == 8'h01)
               open_nal(PREFIX_SHORT, pos);
            else if (!(z2 && z1 && b == 8'h00)) begin
               report_no_start();
               hunting = 1;
            end
         end else if (pos == 32'd3) begin
            if (b == 8'h01)
               open_nal(PREFIX_LONG, pos);
            else begin
               report_no_start();
               hunting = 1;
            end
         end
      end else if (b == 8'h01 && history_len >= 2 && z1 && z2) begin
         p = (history_len >= 3 && z3) ? PREFIX_LONG : PREFIX_SHORT;
         if (unit_open) report_unit(p - 3'd1);
         hunting = 0;
         open_nal(p, pos);
      end else if (unit_open) begin
         if (unit_bytes == '0) unit_header = b;
         if (unit_bytes != COUNT_MAX) unit_bytes = unit_bytes + 24'd1;
      end

      history  = {history[15:0], b};
      if (history_len < 3) history_len++;
      position = pos + 32'd1;

      if (eos) begin
         if (unit_open)
            report_unit(3'd0);
         else if (!hunting)
            report_no_start();
         restart_stream();
      end

      if (predicted_records.size() > first) begin
         tail = predicted_records.pop_back();
         tail.last_of_run = 1'b1;
         predicted_records.insert(predicted_records.size(), tail);
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] b, input logic eos);
      scan_item_type item;
      item.value = b;
      item.last  = eos;
      stream_bytes.insert(stream_bytes.size(), item);
   endtask

   task automatic mark_end();
      scan_item_type item;
      item      = stream_bytes.pop_back();
      item.last = 1'b1;
      stream_bytes.insert(stream_bytes.size(), item);
   endtask

   task automatic add_stream(input logic [7:0] bytes[$]);
      foreach (bytes[i]) add_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // zero-heavy so that stray start codes and emulations turn up inside payloads
   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(9);
      if (r < 3) return 8'h00;
      if (r == 3) return 8'h01;
      return 8'($urandom_range(255));
   endfunction

   // 1..6 units, each a 3- or 4-byte start code and a short payload, eos on the last byte
   task automatic add_clean_stream();
      int units, len;
      units = $urandom_range(1, 6);
      for (int u = 0; u < units; u++) begin
         add_byte(8'h00, 0);
         add_byte(8'h00, 0);
         if ($urandom_range(1)) add_byte(8'h00, 0);
         add_byte(8'h01, 0);
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
         for (int i = 0; i < len; i++)
            add_byte((i == 0) ? 8'($urandom_range(255)) : payload_byte(), 0);
      end
      mark_end();
   endtask

   // short random run, usually a broken opening
   task automatic add_noise_stream();
      int len;
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) add_byte(payload_byte(), 0);
      mark_end();
   endtask

   task automatic add_random_streams(input int n_bytes);
      int start;
      start = stream_bytes.size();
      while (stream_bytes.size() - start < n_bytes) begin
         if ($urandom_range(99) < 80)
            add_clean_stream();
         else
            add_noise_stream();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == REG_LIMIT_ENABLE)
         limit_on = value[0];
      else
         limit_count = value;
   endtask

   // all bytes sent, all records back, then let the pipeline settle
   task automatic drain();
      do @(posedge clock);
      while (stream_bytes.size() > 0 || req_bus.valid || predicted_records.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fault_count++;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // req_ driver: one byte per transaction; prediction runs at the accepting edge
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      scan_item_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            scan_byte(req_bus.stream_byte, req_bus.end_of_stream);
         // present the next byte once the current one is gone
         if (!req_bus.valid || req_bus.ready) begin
            if (stream_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               item = stream_bytes.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.stream_byte   <= item.value;
               req_bus.end_of_stream <= item.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // rsp_ monitor: checks every record transaction and drives ready
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      nal_rec_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_records.size() == 0) begin
               $display("%0t: unexpected record: expected none, actual status %0h index %0h",
                        $time, rsp_bus.status, rsp_bus.unit_index);
               fault_count++;
            end else begin
               want = predicted_records.pop_front();
               check_field("status", want.status, rsp_bus.status);
               check_field("unit_index", want.unit_index, rsp_bus.unit_index);
               check_field("byte_offset", want.byte_offset, rsp_bus.byte_offset);
               check_field("payload_length", want.payload_length, rsp_bus.payload_length);
               check_field("prefix_length", want.prefix_length, rsp_bus.prefix_length);
               check_field("forbid_flag", want.forbid_flag, rsp_bus.forbid_flag);
               check_field("ref_idc", want.ref_idc, rsp_bus.ref_idc);
               check_field("unit_type", want.unit_type, rsp_bus.unit_type);
               check_field("limit_reached", want.limit_reached, rsp_bus.limit_reached);
               check_field("last_of_run", want.last_of_run, rsp_bus.last_of_run);
            end
         end
         // one long hold-off while the sender keeps pushing fills the record queue
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (pressure_req && !pressure_done) begin
            pressure_done = 1;
            hold_left     = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer: directed streams, then random phases under several limit settings
   // ---------------------------------------------------------------------------------
   initial begin : sequencer
      logic [7:0] seq[$];
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.stream_byte   = 8'h00;
      req_bus.end_of_stream = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = REG_LIMIT_ENABLE;
      csr_bus.data          = '0;
      limit_on              = 0;
      limit_count           = NAL_LIMIT_RESET;
      tx_idle_pct           = 12;
      rx_idle_pct           = 74;
      pressure_req          = 0;
      restart_stream();

      // 4-byte opening and empty unit, 4-byte start code mid-stream,
      // final byte completing a start code (two records on one byte)
      seq = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65,
              8'h00, 8'h00, 8'h01};
      add_stream(seq);
      // bad opening, resync on a 3-byte start code, all-ones header
      seq = '{8'h09, 8'h00, 8'h00, 8'h01, 8'hFF};
      add_stream(seq);
      // 00 00 00 then no 01: error, resync picks up the extra zero as a 4-byte prefix
      seq = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
      add_stream(seq);
      // plain 3-byte opening, forbidden bit only
      seq = '{8'h00, 8'h00, 8'h01, 8'h80};
      add_stream(seq);
      // stream ends before the opening is decided
      seq = '{8'h00, 8'h00};
      add_stream(seq);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_random_streams(250);
      drain();

      // limit of zero: at most one unit record per stream
      write_reg(REG_LIMIT_ENABLE, 16'd1);
      write_reg(REG_NAL_LIMIT, 16'd0);
      add_random_streams(240);
      drain();

      tx_idle_pct = 74;
      rx_idle_pct = 12;
      write_reg(REG_NAL_LIMIT, 16'd3);
      add_random_streams(240);
      drain();

      write_reg(REG_NAL_LIMIT, 16'hFFFF);
      add_random_streams(240);
      drain();

      // no idling; long receiver hold-off; limit disabled with a small count loaded
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      write_reg(REG_LIMIT_ENABLE, 16'd0);
      write_reg(REG_NAL_LIMIT, 16'd2);
      pressure_req = 1;
      add_random_streams(240);
      drain();

      write_reg(REG_LIMIT_ENABLE, 16'd1);
      write_reg(REG_NAL_LIMIT, 16'd7);
      add_random_streams(240);
      drain();

      if (fault_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
